### rtl/text_encoding_sniffer_top_defines.svh
// Assertion helpers for the encoding sniffer, clocked on clk and held off in reset.
`ifndef TEXT_ENCODING_SNIFFER_TOP_DEFINES_SVH
`define TEXT_ENCODING_SNIFFER_TOP_DEFINES_SVH

// Same-cycle implication.
`define TES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tes_pkg.sv
`default_nettype none

package tes_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] enc_t;
    typedef logic [2:0] mark_len_t;

    // Encoding codes
    localparam enc_t ENC_UTF8    = 3'd0;
    localparam enc_t ENC_UTF16LE = 3'd1;
    localparam enc_t ENC_UTF16BE = 3'd2;
    localparam enc_t ENC_UTF32LE = 3'd3;
    localparam enc_t ENC_UTF32BE = 3'd4;
    localparam enc_t ENC_LATIN1  = 3'd5;

    // Byte-order mark lengths
    localparam mark_len_t MARK_NONE  = 3'd0;
    localparam mark_len_t MARK_UTF16 = 3'd2;
    localparam mark_len_t MARK_UTF8  = 3'd3;
    localparam mark_len_t MARK_UTF32 = 3'd4;

    // Byte-order mark bytes
    localparam byte_t BOM_NUL = 8'h00;
    localparam byte_t BOM_FF  = 8'hFF;
    localparam byte_t BOM_FE  = 8'hFE;
    localparam byte_t BOM_EF  = 8'hEF;
    localparam byte_t BOM_BB  = 8'hBB;
    localparam byte_t BOM_BF  = 8'hBF;

    // UTF-8 lead and continuation patterns
    localparam byte_t HIGH_BIT   = 8'h80;
    localparam byte_t CONT_MASK  = 8'hC0;
    localparam byte_t CONT_PAT   = 8'h80;
    localparam byte_t LEAD2_MASK = 8'hE0;
    localparam byte_t LEAD2_PAT  = 8'hC0;
    localparam byte_t LEAD3_MASK = 8'hF0;
    localparam byte_t LEAD3_PAT  = 8'hE0;
    localparam byte_t LEAD4_MASK = 8'hF8;
    localparam byte_t LEAD4_PAT  = 8'hF0;

endpackage

`default_nettype wire

### rtl/tes_if.sv
`default_nettype none

// Byte stream channel.
interface tes_byte_if;
    import tes_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last;
    logic  empty_buffer;

    modport source (output valid, output data_byte, output last, output empty_buffer,
                    input ready);
    modport sink   (input valid, input data_byte, input last, input empty_buffer,
                    output ready);
endinterface

// Verdict channel.
interface tes_verdict_if;
    import tes_pkg::*;

    logic      valid;
    logic      ready;
    enc_t      encoding;
    mark_len_t mark_length;

    modport source (output valid, output encoding, output mark_length, input ready);
    modport sink   (input valid, input encoding, input mark_length, output ready);
endinterface

`default_nettype wire

### rtl/text_encoding_sniffer_top.sv
`default_nettype none
// Path: the byte that ends a buffer passes the input register and snapshot; its verdict is then registered.
// Throughput: one byte per cycle while the verdict side does not back up; set by the counter and UTF-8 state update.
// Stages: input register, accumulate/snapshot, decide/output register; each holds on stall.
// Reset: rst_n is asynchronous, active low; it empties all stages and clears the
// accumulators to an empty buffer.
`include "text_encoding_sniffer_top_defines.svh"

module text_encoding_sniffer_top #(
    parameter int COUNT_WIDTH = tes_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tes_byte_if.sink    byte_stream,
    tes_verdict_if.source verdict
);
    import tes_pkg::*;

    localparam int CW = COUNT_WIDTH;

    // ------------------------------------------------------------------
    // Stage handshakes. Each stage moves when the next one is free or
    // moving; a byte that does not end a buffer needs no snapshot slot,
    // so it never waits on the output side.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic snap_valid_reg;
    logic out_valid_reg;

    logic out_take;
    logic snap_free;
    logic item_ends;
    logic acc_fire;
    logic in_free;

    assign out_take  = !out_valid_reg || verdict.ready;
    assign snap_free = !snap_valid_reg || out_take;
    assign acc_fire  = in_valid_reg && (!item_ends || snap_free);
    assign in_free   = !in_valid_reg || acc_fire;

    assign byte_stream.ready = in_free;

    // ------------------------------------------------------------------
    // Input register: capture one transfer.
    // ------------------------------------------------------------------
    byte_t in_byte_reg;
    logic  in_last_reg;
    logic  in_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && byte_stream.valid)
        begin
            in_byte_reg  <= byte_stream.data_byte;
            in_last_reg  <= byte_stream.last;
            in_empty_reg <= byte_stream.empty_buffer;
        end
    end

    // An empty-buffer item ends the buffer whatever its last bit says.
    assign item_ends = in_last_reg || in_empty_reg;

    // ------------------------------------------------------------------
    // Accumulators for the buffer in progress.
    // ------------------------------------------------------------------
    logic [31:0]   head_reg;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] zeros_even_reg;
    logic [CW-1:0] zeros_odd_reg;
    logic [CW-1:0] zeros_low_reg;
    logic [CW-1:0] zeros_high_reg;
    logic          high_seen_reg;
    logic [1:0]    cont_left_reg;
    logic          utf8_ok_reg;
    logic [1:0]    phase_reg;

    // State after taking the byte in the input register.
    logic [31:0]   head_next;
    logic [CW-1:0] total_next;
    logic [CW-1:0] zeros_even_next;
    logic [CW-1:0] zeros_odd_next;
    logic [CW-1:0] zeros_low_next;
    logic [CW-1:0] zeros_high_next;
    logic          high_seen_next;
    logic [1:0]    cont_left_next;
    logic          utf8_ok_next;
    logic [1:0]    phase_next;

    logic          is_zero;

    always_comb
    begin
        is_zero = (in_byte_reg == BOM_NUL);

        // Keep the first four bytes, byte k in lane k.
        head_next = head_reg;
        if (total_reg < CW'(4))
        begin
            head_next[{total_reg[1:0], 3'b000} +: 8] = in_byte_reg;
        end

        // Saturating zero counts by position parity and pair within four.
        zeros_even_next = zeros_even_reg;
        zeros_odd_next  = zeros_odd_reg;
        zeros_low_next  = zeros_low_reg;
        zeros_high_next = zeros_high_reg;
        if (is_zero)
        begin
            if (!phase_reg[0])
            begin
                zeros_even_next = (&zeros_even_reg) ? zeros_even_reg : zeros_even_reg + 1'b1;
            end
            else
            begin
                zeros_odd_next = (&zeros_odd_reg) ? zeros_odd_reg : zeros_odd_reg + 1'b1;
            end
            if (!phase_reg[1])
            begin
                zeros_low_next = (&zeros_low_reg) ? zeros_low_reg : zeros_low_reg + 1'b1;
            end
            else
            begin
                zeros_high_next = (&zeros_high_reg) ? zeros_high_reg : zeros_high_reg + 1'b1;
            end
        end

        high_seen_next = high_seen_reg || ((in_byte_reg & HIGH_BIT) != 8'h00);

        // UTF-8 lead and continuation tracking.
        cont_left_next = cont_left_reg;
        utf8_ok_next   = utf8_ok_reg;
        if (cont_left_reg != 2'd0)
        begin
            if ((in_byte_reg & CONT_MASK) != CONT_PAT)
            begin
                utf8_ok_next = 1'b0;
            end
            cont_left_next = cont_left_reg - 2'd1;
        end
        else if ((in_byte_reg & HIGH_BIT) == 8'h00)
        begin
            cont_left_next = 2'd0;
        end
        else if ((in_byte_reg & LEAD2_MASK) == LEAD2_PAT)
        begin
            cont_left_next = 2'd1;
        end
        else if ((in_byte_reg & LEAD3_MASK) == LEAD3_PAT)
        begin
            cont_left_next = 2'd2;
        end
        else if ((in_byte_reg & LEAD4_MASK) == LEAD4_PAT)
        begin
            cont_left_next = 2'd3;
        end
        else
        begin
            utf8_ok_next = 1'b0;
        end

        total_next = (&total_reg) ? total_reg : total_reg + 1'b1;
        phase_next = phase_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            total_reg      <= '0;
            zeros_even_reg <= '0;
            zeros_odd_reg  <= '0;
            zeros_low_reg  <= '0;
            zeros_high_reg <= '0;
            high_seen_reg  <= 1'b0;
            cont_left_reg  <= 2'd0;
            utf8_ok_reg    <= 1'b1;
            phase_reg      <= 2'd0;
        end
        else if (acc_fire)
        begin
            if (item_ends)
            begin
                // Drop everything once the buffer is handed to the snapshot.
                head_reg       <= '0;
                total_reg      <= '0;
                zeros_even_reg <= '0;
                zeros_odd_reg  <= '0;
                zeros_low_reg  <= '0;
                zeros_high_reg <= '0;
                high_seen_reg  <= 1'b0;
                cont_left_reg  <= 2'd0;
                utf8_ok_reg    <= 1'b1;
                phase_reg      <= 2'd0;
            end
            else
            begin
                head_reg       <= head_next;
                total_reg      <= total_next;
                zeros_even_reg <= zeros_even_next;
                zeros_odd_reg  <= zeros_odd_next;
                zeros_low_reg  <= zeros_low_next;
                zeros_high_reg <= zeros_high_next;
                high_seen_reg  <= high_seen_next;
                cont_left_reg  <= cont_left_next;
                utf8_ok_reg    <= utf8_ok_next;
                phase_reg      <= phase_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot of a finished buffer. An empty-buffer item snapshots the
    // cleared state, which the decision maps to UTF-8 with no mark.
    // ------------------------------------------------------------------
    logic [31:0]   snap_head_reg;
    logic [CW-1:0] snap_total_reg;
    logic [CW-1:0] snap_even_reg;
    logic [CW-1:0] snap_odd_reg;
    logic [CW-1:0] snap_low_reg;
    logic [CW-1:0] snap_high_reg;
    logic          snap_high_seen_reg;
    logic [1:0]    snap_cont_reg;
    logic          snap_ok_reg;

    logic snap_load;
    assign snap_load = acc_fire && item_ends;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_free)
        begin
            snap_valid_reg <= snap_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            if (in_empty_reg)
            begin
                snap_head_reg      <= '0;
                snap_total_reg     <= '0;
                snap_even_reg      <= '0;
                snap_odd_reg       <= '0;
                snap_low_reg       <= '0;
                snap_high_reg      <= '0;
                snap_high_seen_reg <= 1'b0;
                snap_cont_reg      <= 2'd0;
                snap_ok_reg        <= 1'b1;
            end
            else
            begin
                snap_head_reg      <= head_next;
                snap_total_reg     <= total_next;
                snap_even_reg      <= zeros_even_next;
                snap_odd_reg       <= zeros_odd_next;
                snap_low_reg       <= zeros_low_next;
                snap_high_reg      <= zeros_high_next;
                snap_high_seen_reg <= high_seen_next;
                snap_cont_reg      <= cont_left_next;
                snap_ok_reg        <= utf8_ok_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Decision: mark rules first, then zero statistics, then UTF-8 check.
    // ------------------------------------------------------------------
    byte_t       b0;
    byte_t       b1;
    byte_t       b2;
    byte_t       b3;
    logic        has2;
    logic        has3;
    logic        has4;
    logic [CW:0]   nulls;
    logic [CW+1:0] nulls_twice;
    logic        any_zero;
    logic        mostly_zero;
    enc_t        enc_next;
    mark_len_t   mark_next;

    always_comb
    begin
        b0 = snap_head_reg[7:0];
        b1 = snap_head_reg[15:8];
        b2 = snap_head_reg[23:16];
        b3 = snap_head_reg[31:24];
        has2 = (snap_total_reg >= CW'(2));
        has3 = (snap_total_reg >= CW'(3));
        has4 = (snap_total_reg >= CW'(4));

        nulls       = {1'b0, snap_even_reg} + {1'b0, snap_odd_reg};
        nulls_twice = {nulls, 1'b0};
        any_zero    = (|snap_even_reg) || (|snap_odd_reg);
        mostly_zero = (nulls_twice > {2'b00, snap_total_reg});

        mark_next = MARK_NONE;
        if (has4 && b0 == BOM_FF && b1 == BOM_FE && b2 == BOM_NUL && b3 == BOM_NUL)
        begin
            enc_next  = ENC_UTF32LE;
            mark_next = MARK_UTF32;
        end
        else if (has4 && b0 == BOM_NUL && b1 == BOM_NUL && b2 == BOM_FE && b3 == BOM_FF)
        begin
            enc_next  = ENC_UTF32BE;
            mark_next = MARK_UTF32;
        end
        else if (has3 && b0 == BOM_EF && b1 == BOM_BB && b2 == BOM_BF)
        begin
            enc_next  = ENC_UTF8;
            mark_next = MARK_UTF8;
        end
        else if (has2 && b0 == BOM_FF && b1 == BOM_FE)
        begin
            enc_next  = ENC_UTF16LE;
            mark_next = MARK_UTF16;
        end
        else if (has2 && b0 == BOM_FE && b1 == BOM_FF)
        begin
            enc_next  = ENC_UTF16BE;
            mark_next = MARK_UTF16;
        end
        else if (any_zero)
        begin
            // Ties fall to little endian.
            if (mostly_zero)
            begin
                enc_next = (snap_low_reg > snap_high_reg) ? ENC_UTF32BE : ENC_UTF32LE;
            end
            else
            begin
                enc_next = (snap_even_reg > snap_odd_reg) ? ENC_UTF16BE : ENC_UTF16LE;
            end
        end
        else if (snap_ok_reg && snap_cont_reg == 2'd0)
        begin
            enc_next = ENC_UTF8;
        end
        else if (snap_high_seen_reg)
        begin
            enc_next = ENC_LATIN1;
        end
        else
        begin
            enc_next = ENC_UTF8;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the verdict until its transfer.
    // ------------------------------------------------------------------
    enc_t      out_enc_reg;
    mark_len_t out_mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && snap_valid_reg)
        begin
            out_enc_reg  <= enc_next;
            out_mark_reg <= mark_next;
        end
    end

    assign verdict.valid       = out_valid_reg;
    assign verdict.encoding    = out_enc_reg;
    assign verdict.mark_length = out_mark_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TES_ASSERT_NEXT(a_end_reaches_snapshot, snap_load, snap_valid_reg,
        "finished buffer did not reach the snapshot stage")
    `TES_ASSERT_NEXT(a_snapshot_holds, snap_valid_reg && !out_take, snap_valid_reg,
        "snapshot lost while the output was stalled")
    `TES_ASSERT_NOW(a_mark3_is_utf8, out_valid_reg && out_mark_reg == MARK_UTF8,
        out_enc_reg == ENC_UTF8, "three-byte mark with a non-UTF-8 verdict")
    `TES_ASSERT_NOW(a_mark4_is_utf32, out_valid_reg && out_mark_reg == MARK_UTF32,
        out_enc_reg == ENC_UTF32LE || out_enc_reg == ENC_UTF32BE,
        "four-byte mark with a non-UTF-32 verdict")

endmodule

`default_nettype wire

### tb/sv/text_encoding_sniffer_top_tb.sv
module text_encoding_sniffer_top_tb;
    import tes_pkg::*;

    // Run the block with narrow counters so that saturation is reachable in a
    // short run; the predictor follows the same width.
    localparam int CNT_W = 8;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;

    // Items to send after the directed table, the long zero run among them.
    localparam int RANDOM_ITEMS = 725;
    // Long output hold-off that backs the pipeline up into the byte input.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any transfer before the run is declared hung. The slowest
    // correct stretch is the hold-off above plus a long source gap.
    localparam int STALL_LIMIT = 3000;
    // Cycles to keep watching for a stray verdict once none is owed.
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        enc_t      encoding;
        mark_len_t mark_length;
    } verdict_t;

    // One row of the directed table. typed marks rows whose verdict is written
    // out by hand; all other rows take the verdict from the predictor.
    typedef struct {
        byte_t     data;
        bit        last;
        bit        empty;
        bit        typed;
        enc_t      encoding;
        mark_len_t mark_length;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tes_byte_if    byte_ch ();
    tes_verdict_if verdict_ch ();

    text_encoding_sniffer_top #(
        .COUNT_WIDTH (CNT_W)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_ch),
        .verdict     (verdict_ch)
    );

    // Verdicts still owed by the block, oldest first.
    verdict_t pending_verdicts[$];
    // Bytes of the buffer about to be sent.
    byte_t    text_q[$];

    int fail_count  = 0;
    int items_sent  = 0;
    bit src_calm    = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    bit hold_active = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of what the block accumulates over
    // one buffer.
    // ------------------------------------------------------------------
    logic [31:0]     sn_head;
    longint unsigned sn_total;
    longint unsigned sn_zero_even;
    longint unsigned sn_zero_odd;
    longint unsigned sn_zero_low;
    longint unsigned sn_zero_high;
    bit              sn_high;
    bit [1:0]        sn_cont_due;
    bit              sn_utf8_good;
    bit [1:0]        sn_pos;

    function automatic void sniff_clear();
        sn_head      = '0;
        sn_total     = 0;
        sn_zero_even = 0;
        sn_zero_odd  = 0;
        sn_zero_low  = 0;
        sn_zero_high = 0;
        sn_high      = 1'b0;
        sn_cont_due  = 2'd0;
        sn_utf8_good = 1'b1;
        sn_pos       = 2'd0;
    endfunction

    function automatic longint unsigned sat_bump(longint unsigned v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    // Fold one byte into the counters and the UTF-8 tracker.
    function automatic void sniff_byte(byte_t c);
        if (sn_total < 4)
            sn_head[8 * int'(sn_total) +: 8] = c;

        if (c == 8'h00) begin
            if (sn_pos[0] == 1'b0)
                sn_zero_even = sat_bump(sn_zero_even);
            else
                sn_zero_odd = sat_bump(sn_zero_odd);
            if (sn_pos < 2'd2)
                sn_zero_low = sat_bump(sn_zero_low);
            else
                sn_zero_high = sat_bump(sn_zero_high);
        end
        if ((c & HIGH_BIT) != 8'h00)
            sn_high = 1'b1;

        if (sn_cont_due != 2'd0) begin
            if ((c & CONT_MASK) != CONT_PAT)
                sn_utf8_good = 1'b0;
            sn_cont_due = sn_cont_due - 2'd1;
        end else if ((c & HIGH_BIT) == 8'h00) begin
            sn_cont_due = 2'd0;
        end else if ((c & LEAD2_MASK) == LEAD2_PAT) begin
            sn_cont_due = 2'd1;
        end else if ((c & LEAD3_MASK) == LEAD3_PAT) begin
            sn_cont_due = 2'd2;
        end else if ((c & LEAD4_MASK) == LEAD4_PAT) begin
            sn_cont_due = 2'd3;
        end else begin
            sn_utf8_good = 1'b0;
        end

        sn_total = sat_bump(sn_total);
        sn_pos   = sn_pos + 2'd1;
    endfunction

    // Marks first, in priority order, then the zero statistics, then UTF-8.
    function automatic verdict_t sniff_decide();
        verdict_t        v;
        byte_t           b0;
        byte_t           b1;
        byte_t           b2;
        byte_t           b3;
        longint unsigned nulls;
        b0 = sn_head[7:0];
        b1 = sn_head[15:8];
        b2 = sn_head[23:16];
        b3 = sn_head[31:24];
        v.mark_length = MARK_NONE;
        if (sn_total >= 4 && b0 == BOM_FF && b1 == BOM_FE && b2 == BOM_NUL && b3 == BOM_NUL) begin
            v.encoding    = ENC_UTF32LE;
            v.mark_length = MARK_UTF32;
        end else if (sn_total >= 4 && b0 == BOM_NUL && b1 == BOM_NUL && b2 == BOM_FE
                     && b3 == BOM_FF) begin
            v.encoding    = ENC_UTF32BE;
            v.mark_length = MARK_UTF32;
        end else if (sn_total >= 3 && b0 == BOM_EF && b1 == BOM_BB && b2 == BOM_BF) begin
            v.encoding    = ENC_UTF8;
            v.mark_length = MARK_UTF8;
        end else if (sn_total >= 2 && b0 == BOM_FF && b1 == BOM_FE) begin
            v.encoding    = ENC_UTF16LE;
            v.mark_length = MARK_UTF16;
        end else if (sn_total >= 2 && b0 == BOM_FE && b1 == BOM_FF) begin
            v.encoding    = ENC_UTF16BE;
            v.mark_length = MARK_UTF16;
        end else begin
            nulls = sn_zero_even + sn_zero_odd;
            if (nulls > 0) begin
                // Strictly more than half zeros, compared without rounding.
                if (2 * nulls > sn_total)
                    v.encoding = (sn_zero_low > sn_zero_high) ? ENC_UTF32BE : ENC_UTF32LE;
                else
                    v.encoding = (sn_zero_even > sn_zero_odd) ? ENC_UTF16BE : ENC_UTF16LE;
            end else if (sn_utf8_good && sn_cont_due == 2'd0) begin
                v.encoding = ENC_UTF8;
            end else if (sn_high) begin
                v.encoding = ENC_LATIN1;
            end else begin
                v.encoding = ENC_UTF8;
            end
        end
        return v;
    endfunction

    // Advance the predictor by one accepted item; return 1 when it owes a verdict.
    function automatic bit sniff_item(byte_t d, bit lst, bit emp, output verdict_t v);
        v.encoding    = ENC_UTF8;
        v.mark_length = MARK_NONE;
        if (emp) begin
            // Empty-buffer item: drop whatever was pending, answer UTF-8.
            sniff_clear();
            return 1'b1;
        end
        sniff_byte(d);
        if (!lst)
            return 1'b0;
        v = sniff_decide();
        sniff_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Buffer generators
    // ------------------------------------------------------------------
    function automatic byte_t pick_cont();
        return byte_t'($urandom_range(8'hBF, 8'h80));
    endfunction

    function automatic byte_t pick_zero_biased();
        return ($urandom_range(2, 0) == 0) ? 8'h00 : byte_t'($urandom_range(255, 0));
    endfunction

    // Push a UTF-8 lead of the given length followed by conts continuation bytes.
    function automatic void push_utf8_char(int len, int conts);
        case (len)
            1:       text_q.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
            2:       text_q.push_back(byte_t'($urandom_range(8'hDF, 8'hC2)));
            3:       text_q.push_back(byte_t'($urandom_range(8'hEF, 8'hE0)));
            default: text_q.push_back(byte_t'($urandom_range(8'hF7, 8'hF0)));
        endcase
        repeat (conts) text_q.push_back(pick_cont());
    endfunction

    // Fill text_q with one buffer of a randomly chosen flavor. An empty queue
    // stands for a lone empty-buffer item. abort asks for the buffer to be cut
    // short by an empty-buffer item instead of a closing byte.
    function automatic void fill_text(output bit abort);
        logic [31:0] bom_word;
        int          bom_len;
        int          keep;
        int          n;
        int          len;
        text_q.delete();
        abort = ($urandom_range(99, 0) < 6);
        case ($urandom_range(11, 0))
            0: begin
                case ($urandom_range(4, 0))
                    0:       begin bom_word = {BOM_FF, BOM_FE, BOM_NUL, BOM_NUL}; bom_len = 4; end
                    1:       begin bom_word = {BOM_NUL, BOM_NUL, BOM_FE, BOM_FF}; bom_len = 4; end
                    2:       begin bom_word = {BOM_EF, BOM_BB, BOM_BF, 8'h00};    bom_len = 3; end
                    3:       begin bom_word = {BOM_FF, BOM_FE, 8'h00, 8'h00};     bom_len = 2; end
                    default: begin bom_word = {BOM_FE, BOM_FF, 8'h00, 8'h00};     bom_len = 2; end
                endcase
                // Sometimes end the buffer inside the mark, so the length guard matters.
                if ($urandom_range(3, 0) == 0) begin
                    keep = $urandom_range(bom_len - 1, 1);
                    n    = 0;
                end else begin
                    keep = bom_len;
                    n    = $urandom_range(6, 0);
                end
                for (int i = 0; i < keep; i++)
                    text_q.push_back(bom_word[31 - 8 * i -: 8]);
                repeat (n) text_q.push_back(pick_zero_biased());
            end
            1: repeat ($urandom_range(8, 1)) begin
                text_q.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
                text_q.push_back(8'h00);
            end
            2: repeat ($urandom_range(8, 1)) begin
                text_q.push_back(8'h00);
                text_q.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
            end
            3: repeat ($urandom_range(3, 1)) begin
                text_q.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
                repeat (3) text_q.push_back(8'h00);
            end
            4: repeat ($urandom_range(3, 1)) begin
                repeat (3) text_q.push_back(8'h00);
                text_q.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
            end
            5: repeat ($urandom_range(6, 1)) begin
                len = $urandom_range(4, 1);
                push_utf8_char(len, len - 1);
            end
            6: begin
                // Well-formed text that stops in the middle of a sequence.
                repeat ($urandom_range(3, 0)) begin
                    len = $urandom_range(4, 1);
                    push_utf8_char(len, len - 1);
                end
                len = $urandom_range(4, 2);
                push_utf8_char(len, $urandom_range(len - 2, 0));
            end
            7: repeat ($urandom_range(10, 1))
                text_q.push_back(byte_t'($urandom_range(255, 1)));
            8: repeat ($urandom_range(10, 1))
                text_q.push_back(byte_t'($urandom_range(8'h7F, 8'h01)));
            9: repeat ($urandom_range(12, 1))
                text_q.push_back(pick_zero_biased());
            10: repeat ($urandom_range(3, 1)) begin
                case ($urandom_range(7, 0))
                    0:       text_q.push_back(8'h00);
                    1:       text_q.push_back(BOM_FF);
                    2:       text_q.push_back(BOM_FE);
                    3:       text_q.push_back(BOM_EF);
                    4:       text_q.push_back(BOM_BB);
                    5:       text_q.push_back(BOM_BF);
                    6:       text_q.push_back(CONT_PAT);
                    default: text_q.push_back(LEAD2_PAT);
                endcase
            end
            default: abort = 1'b0;
        endcase
    endfunction

    // Source idle length: mostly none or short, now and then long. Hold the
    // valid high during the output hold-off so the input side backs up.
    function automatic int src_gap();
        int r;
        if (src_calm || hold_active || (hold_req && !hold_done))
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // ------------------------------------------------------------------
    // Byte channel driver: change inputs on the falling edge, detect the
    // transfer on the rising edge, then predict.
    // ------------------------------------------------------------------
    task automatic offer(input byte_t d, input bit lst, input bit emp,
                         input bit typed, input enc_t t_enc, input mark_len_t t_mark);
        int       gap;
        verdict_t v;
        gap = src_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= d;
        byte_ch.last         <= lst;
        byte_ch.empty_buffer <= emp;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        items_sent++;
        if (sniff_item(d, lst, emp, v)) begin
            if (typed) begin
                v.encoding    = t_enc;
                v.mark_length = t_mark;
            end
            pending_verdicts.push_back(v);
        end
        @(negedge clk);
    endtask

    // Send text_q as one buffer; an empty queue sends a lone empty-buffer item.
    task automatic send_text(input bit abort);
        if (text_q.size() == 0) begin
            offer(byte_t'($urandom_range(255, 0)), bit'($urandom_range(1, 0)), 1'b1,
                  1'b0, ENC_UTF8, MARK_NONE);
        end else begin
            foreach (text_q[i])
                offer(text_q[i], (i == text_q.size() - 1) && !abort, 1'b0,
                      1'b0, ENC_UTF8, MARK_NONE);
            // Cut the buffer short: the pending bytes are dropped.
            if (abort)
                offer(byte_t'($urandom_range(255, 0)), bit'($urandom_range(1, 0)), 1'b1,
                      1'b0, ENC_UTF8, MARK_NONE);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Verdict sink: ready changes on the falling edge. Alternate calm
    // stretches with noisy ones, and once hold ready low for a long time.
    // ------------------------------------------------------------------
    initial begin : verdict_sink
        int stall_left;
        int mode_left;
        bit calm;
        stall_left       = 0;
        mode_left        = 0;
        calm             = 1'b0;
        verdict_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                calm      = ($urandom_range(3, 0) == 0);
                mode_left = $urandom_range(80, 20);
            end
            mode_left--;
            if (hold_req && !hold_done) begin
                hold_done        = 1'b1;
                hold_active      = 1'b1;
                verdict_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active      = 1'b0;
            end else if (stall_left > 0) begin
                verdict_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                verdict_ch.ready <= 1'b1;
                if (!calm && $urandom_range(99, 0) < 25)
                    stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 10)
                                                            : $urandom_range(3, 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict checker: compare every transfer with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        verdict_t exp_v;
        if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict with nothing expected: encoding %0d, mark length %0d",
                         $time, verdict_ch.encoding, verdict_ch.mark_length);
                fail_count++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (verdict_ch.encoding !== exp_v.encoding) begin
                    $display("%0t: encoding mismatch: expected %0d, actual %0d",
                             $time, exp_v.encoding, verdict_ch.encoding);
                    fail_count++;
                end
                if (verdict_ch.mark_length !== exp_v.mark_length) begin
                    $display("%0t: mark length mismatch: expected %0d, actual %0d",
                             $time, exp_v.mark_length, verdict_ch.mark_length);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens on either channel for
    // too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
                 $time, STALL_LIMIT, pending_verdicts.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random buffers, drain, verdict.
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t rows[$];
        bit        abort;
        int        start_count;
        bit        long_zero_done;

        // Hold every input at a known value while reset is low.
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'h00;
        byte_ch.last         = 1'b0;
        byte_ch.empty_buffer = 1'b0;
        long_zero_done       = 1'b0;
        sniff_clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        //                data    last  empty typed encoding     mark length
        // Empty buffer straight out of reset.
        rows.push_back('{8'h00,  1'b0, 1'b1, 1'b1, ENC_UTF8,    MARK_NONE});
        // Each byte-order mark on its own.
        rows.push_back('{BOM_FF, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_FE, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{8'h00,  1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{8'h00,  1'b1, 1'b0, 1'b1, ENC_UTF32LE, MARK_UTF32});
        rows.push_back('{8'h00,  1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{8'h00,  1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_FE, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_FF, 1'b1, 1'b0, 1'b1, ENC_UTF32BE, MARK_UTF32});
        rows.push_back('{BOM_EF, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_BB, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_BF, 1'b1, 1'b0, 1'b1, ENC_UTF8,    MARK_UTF8});
        rows.push_back('{BOM_FF, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_FE, 1'b1, 1'b0, 1'b1, ENC_UTF16LE, MARK_UTF16});
        rows.push_back('{BOM_FE, 1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{BOM_FF, 1'b1, 1'b0, 1'b1, ENC_UTF16BE, MARK_UTF16});
        // Single zero byte: all zeros in the low pair, so big-endian UTF-32.
        rows.push_back('{8'h00,  1'b1, 1'b0, 1'b1, ENC_UTF32BE, MARK_NONE});
        // Top byte value and top ASCII value alone.
        rows.push_back('{8'hFF,  1'b1, 1'b0, 1'b1, ENC_LATIN1,  MARK_NONE});
        rows.push_back('{8'h7F,  1'b1, 1'b0, 1'b1, ENC_UTF8,    MARK_NONE});
        // Two-byte lead with its continuation missing.
        rows.push_back('{8'hC3,  1'b1, 1'b0, 1'b1, ENC_LATIN1,  MARK_NONE});
        // Complete two-byte sequence.
        rows.push_back('{8'hC3,  1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{8'hA9,  1'b1, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        // Pending byte dropped by an empty-buffer item that also carries last.
        rows.push_back('{8'h41,  1'b0, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});
        rows.push_back('{8'hFF,  1'b1, 1'b1, 1'b1, ENC_UTF8,    MARK_NONE});
        // Stray continuation byte.
        rows.push_back('{8'h80,  1'b1, 1'b0, 1'b0, ENC_UTF8,    MARK_NONE});

        foreach (rows[i])
            offer(rows[i].data, rows[i].last, rows[i].empty,
                  rows[i].typed, rows[i].encoding, rows[i].mark_length);

        // Ask the sink for its long hold-off while random buffers keep coming.
        hold_req    = 1'b1;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if (!long_zero_done && items_sent - start_count > 100) begin
                // Long run of mostly zeros: the byte count and every zero
                // counter saturate.
                long_zero_done = 1'b1;
                text_q.delete();
                repeat (560)
                    text_q.push_back(($urandom_range(19, 0) == 0)
                                     ? byte_t'($urandom_range(255, 1)) : 8'h00);
                src_calm = 1'b0;
                send_text(1'b0);
            end else begin
                fill_text(abort);
                // Some buffers go out back to back with no source gaps.
                src_calm = ($urandom_range(3, 0) == 0);
                send_text(abort);
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain: wait for the last owed verdict, then watch a little longer
        // for anything unexpected.
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/tes_pkg.sv
rtl/tes_if.sv
rtl/text_encoding_sniffer_top.sv
tb/sv/text_encoding_sniffer_top_tb.sv
